// ===== design/tic_pkg.sv =====
// Shared types and constants of the timer and interrupt controller.
package tic_pkg;

	// Field widths fixed by the block's interface.
	localparam int TICK_W     = 5;
	localparam int FLAG_W     = 5;
	localparam int CNT_W      = 8;
	localparam int GAP_W      = 12;
	localparam int CTRL_W     = 3;
	localparam int VEC_W      = 8;
	localparam int SRC_IDX_W  = 3;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	// Bit positions inside the control register and the flag word.
	localparam int CTRL_ON_BIT = 2;
	localparam int TIMER_IDX   = 2;
	localparam int KEYPAD_IDX  = 4;

	localparam logic [CNT_W-1:0] COUNT_MAX   = 8'hFF;
	localparam logic [VEC_W-1:0] VECTOR_BASE = 8'h40;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TIMER_CONTROL    = 2'd0,
		REG_TIMER_MODULO     = 2'd1,
		REG_INTERRUPT_ENABLE = 2'd2
	} cfg_reg_t;

	// Interval select codes of the timer control register.
	typedef enum logic [1:0] {
		TSEL_64 = 2'b00,
		TSEL_1  = 2'b01,
		TSEL_4  = 2'b10,
		TSEL_16 = 2'b11
	} tsel_t;

	// Outcome of the dispatch check.
	typedef struct packed {
		logic              taken;
		logic [VEC_W-1:0]  vector;
		logic [FLAG_W-1:0] clear;
	} disp_t;

endpackage

// ===== design/tic_if.sv =====
// Handshake channels of the timer and interrupt controller.
interface tic_item_if;
	logic                       valid;
	logic                       ready;
	logic [tic_pkg::TICK_W-1:0] ticks;
	logic [tic_pkg::FLAG_W-1:0] request_mask;
	logic                       set_master_enable;

	modport source (output valid, ticks, request_mask, set_master_enable, input ready);
	modport sink (input valid, ticks, request_mask, set_master_enable, output ready);
endinterface

interface tic_result_if;
	logic                       valid;
	logic                       ready;
	logic [tic_pkg::CNT_W-1:0]  divider_value;
	logic [tic_pkg::CNT_W-1:0]  timer_value;
	logic [tic_pkg::FLAG_W-1:0] pending_flags;
	logic                       dispatch;
	logic [tic_pkg::VEC_W-1:0]  vector_address;
	logic                       halt_release;
	logic                       stop_release;

	modport source (output valid, divider_value, timer_value, pending_flags, dispatch,
		vector_address, halt_release, stop_release, input ready);
	modport sink (input valid, divider_value, timer_value, pending_flags, dispatch,
		vector_address, halt_release, stop_release, output ready);
endinterface

interface tic_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [tic_pkg::CFG_IDX_W-1:0]  index;
	logic [tic_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ===== design/tic_arbiter.sv =====
// Priority pick of the lowest enabled pending interrupt source.
module tic_arbiter (
	input  logic                       master,
	input  logic [tic_pkg::FLAG_W-1:0] ready_set,
	output tic_pkg::disp_t             disp
);
	import tic_pkg::*;

	logic [SRC_IDX_W-1:0] idx;
	logic [FLAG_W-1:0]    onehot;

	// Walk from the top down so the lowest set bit wins.
	always_comb begin
		idx = '0;
		onehot = '0;
		for (int i = FLAG_W - 1; i >= 0; i--) begin
			if (ready_set[i]) begin
				idx = SRC_IDX_W'(i);
				onehot = FLAG_W'(1) << i;
			end
		end
	end

	// A source is taken only with the master enable set.
	always_comb begin
		disp.taken = master && (ready_set != '0);
		disp.vector = disp.taken ? VECTOR_BASE + {2'b00, idx, 3'b000} : '0;
		disp.clear = disp.taken ? onehot : '0;
	end

endmodule

// ===== design/timer_and_interrupt_controller_top.sv =====
// Top level of the timer and interrupt controller.
//
//  Channel  Dir  Beat contents
//  -------  ---  ------------------------------------------------------------
//  item     in   ticks, request_mask, set_master_enable (one instruction)
//  result   out  divider/timer values, pending flags, dispatch, vector, wakes
//  cfg      in   index, data (timer control, timer modulo, interrupt enable)
//
// One item per cycle is sustained while results are taken. A beat is captured in an
// input register and its result lands in the output register when the beat leaves
// the input stage. The divider, timer and dispatch logic share that single stage.
// Reset clears the block state, the valid bits and the configuration registers to zero.
// When the result is not taken, the input stage holds one beat and then stalls.
module timer_and_interrupt_controller_top #(
	parameter int DIV_PERIOD = 256,
	parameter int TICK_UNIT  = 4,
	parameter int SOURCES    = 5
) (
	input logic         clk,
	input logic         arst_n,
	tic_item_if.sink    item,
	tic_result_if.source result,
	tic_cfg_if.sink     cfg
);
	import tic_pkg::*;

	localparam logic [FLAG_W-1:0] FLAG_MASK =
		(SOURCES >= FLAG_W) ? {FLAG_W{1'b1}} : FLAG_W'((1 << SOURCES) - 1);
	localparam logic signed [GAP_W-1:0] DIV_STEP = GAP_W'(DIV_PERIOD);
	localparam logic signed [GAP_W-1:0] IVL_64   = GAP_W'(TICK_UNIT * 64);
	localparam logic signed [GAP_W-1:0] IVL_1    = GAP_W'(TICK_UNIT);
	localparam logic signed [GAP_W-1:0] IVL_4    = GAP_W'(TICK_UNIT * 4);
	localparam logic signed [GAP_W-1:0] IVL_16   = GAP_W'(TICK_UNIT * 16);
	localparam logic signed [GAP_W-1:0] GAP_MIN  = {1'b1, {(GAP_W - 1){1'b0}}};

	// Subtract ticks from a deadline gap, saturating at the most negative value.
	function automatic logic signed [GAP_W-1:0] gap_sub(
		input logic signed [GAP_W-1:0] gap,
		input logic [TICK_W-1:0]       t
	);
		logic signed [GAP_W:0] d;
		d = {gap[GAP_W-1], gap} - {{(GAP_W + 1 - TICK_W){1'b0}}, t};
		if (d[GAP_W] && !d[GAP_W-1])
			return GAP_MIN;
		return d[GAP_W-1:0];
	endfunction

	// Configuration registers.
	logic [CTRL_W-1:0] ctrl_q;
	logic [CNT_W-1:0]  modulo_q;
	logic [FLAG_W-1:0] ie_q;

	// Block state.
	logic                    me_q;
	logic [FLAG_W-1:0]       flags_q;
	logic [CNT_W-1:0]        div_cnt_q;
	logic signed [GAP_W-1:0] div_gap_q;
	logic [CNT_W-1:0]        tmr_cnt_q;
	logic signed [GAP_W-1:0] tmr_gap_q;
	logic                    tmr_run_q;
	logic                    stop_q;

	// Input stage.
	logic              valid_s1;
	logic [TICK_W-1:0] ticks_s1;
	logic [FLAG_W-1:0] req_s1;
	logic              set_me_s1;

	// Output register.
	logic              res_valid_q;
	logic [CNT_W-1:0]  res_div_q;
	logic [CNT_W-1:0]  res_tmr_q;
	logic [FLAG_W-1:0] res_flags_q;
	logic              res_disp_q;
	logic [VEC_W-1:0]  res_vec_q;
	logic              res_halt_q;
	logic              res_stop_q;

	// Next-state values.
	logic                    adv;
	logic signed [GAP_W-1:0] div_gap_d;
	logic                    div_due;
	logic signed [GAP_W-1:0] div_gap_n;
	logic [CNT_W-1:0]        div_cnt_n;
	logic signed [GAP_W-1:0] tmr_base;
	logic signed [GAP_W-1:0] tmr_ivl;
	logic signed [GAP_W-1:0] tmr_gap_n;
	logic [CNT_W-1:0]        tmr_cnt_n;
	logic                    tmr_run_n;
	logic                    tmr_due;
	logic                    tmr_raise;
	logic [FLAG_W-1:0]       req_m;
	logic                    raised;
	logic [FLAG_W-1:0]       flags_mid;
	logic                    stop_n;
	logic                    me_mid;
	logic [FLAG_W-1:0]       ready_set;
	logic [FLAG_W-1:0]       flags_n;
	logic                    me_n;
	disp_t                   disp;

	// Handshakes: the stage moves on whenever the output register is free or drains.
	assign adv = valid_s1 && (!res_valid_q || result.ready);
	assign item.ready = !valid_s1 || adv;
	assign cfg.ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q <= '0;
			modulo_q <= '0;
			ie_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_TIMER_CONTROL:    ctrl_q <= cfg.data[CTRL_W-1:0];
				REG_TIMER_MODULO:     modulo_q <= cfg.data[CNT_W-1:0];
				REG_INTERRUPT_ENABLE: ie_q <= cfg.data[FLAG_W-1:0];
				default: ;
			endcase
		end
	end

	// Divider: one count per step once its deadline has passed.
	always_comb begin
		div_gap_d = gap_sub(div_gap_q, ticks_s1);
		div_due = div_gap_d[GAP_W-1] || (div_gap_d == '0);
		div_gap_n = div_due ? div_gap_d + DIV_STEP : div_gap_d;
		div_cnt_n = div_due ? div_cnt_q + CNT_W'(1) : div_cnt_q;
	end

	// Interval for the selected timer rate.
	always_comb begin
		unique case (tsel_t'(ctrl_q[1:0]))
			TSEL_64: tmr_ivl = IVL_64;
			TSEL_1:  tmr_ivl = IVL_1;
			TSEL_4:  tmr_ivl = IVL_4;
			TSEL_16: tmr_ivl = IVL_16;
			default: tmr_ivl = IVL_64;
		endcase
	end

	// Programmable timer: due at once when switched on, reloads on overflow.
	always_comb begin
		tmr_run_n = tmr_run_q;
		tmr_base = tmr_gap_q;
		tmr_due = 1'b0;
		if (ctrl_q[CTRL_ON_BIT]) begin
			tmr_run_n = 1'b1;
			if (!tmr_run_q) begin
				tmr_base = '0;
				tmr_due = 1'b1;
			end else begin
				tmr_base = gap_sub(tmr_gap_q, ticks_s1);
				tmr_due = tmr_base[GAP_W-1] || (tmr_base == '0);
			end
		end else begin
			tmr_run_n = 1'b0;
		end
		tmr_gap_n = tmr_due ? tmr_base + tmr_ivl : tmr_base;
		tmr_raise = 1'b0;
		tmr_cnt_n = tmr_cnt_q;
		if (tmr_due) begin
			if (tmr_cnt_q == COUNT_MAX) begin
				tmr_cnt_n = modulo_q;
				tmr_raise = FLAG_MASK[TIMER_IDX];
			end else begin
				tmr_cnt_n = tmr_cnt_q + CNT_W'(1);
			end
		end
	end

	// Request merge and wake tracking.
	always_comb begin
		req_m = req_s1 & FLAG_MASK;
		raised = tmr_raise || (req_m != '0);
		flags_mid = flags_q | req_m | (tmr_raise ? (FLAG_W'(1) << TIMER_IDX) : '0);
		stop_n = raised ? flags_mid[KEYPAD_IDX] : stop_q;
		me_mid = me_q || set_me_s1;
		ready_set = flags_mid & ie_q & FLAG_MASK;
	end

	tic_arbiter u_arb (
		.master    (me_mid),
		.ready_set (ready_set),
		.disp      (disp)
	);

	// Dispatch clears the taken flag and the master enable.
	always_comb begin
		flags_n = flags_mid & ~disp.clear;
		me_n = disp.taken ? 1'b0 : me_mid;
	end

	// State update, one step per beat leaving the input stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			me_q <= 1'b0;
			flags_q <= '0;
			div_cnt_q <= '0;
			div_gap_q <= '0;
			tmr_cnt_q <= '0;
			tmr_gap_q <= '0;
			tmr_run_q <= 1'b0;
			stop_q <= 1'b0;
		end else if (adv) begin
			me_q <= me_n;
			flags_q <= flags_n;
			div_cnt_q <= div_cnt_n;
			div_gap_q <= div_gap_n;
			tmr_cnt_q <= tmr_cnt_n;
			tmr_gap_q <= tmr_gap_n;
			tmr_run_q <= tmr_run_n;
			stop_q <= stop_n;
		end
	end

	// Input stage valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.valid && item.ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Input stage payload.
	always_ff @(posedge clk) begin
		if (item.valid && item.ready) begin
			ticks_s1 <= item.ticks;
			req_s1 <= item.request_mask;
			set_me_s1 <= item.set_master_enable;
		end
	end

	// Output register valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			res_div_q <= div_cnt_n;
			res_tmr_q <= tmr_cnt_n;
			res_flags_q <= flags_n;
			res_disp_q <= disp.taken;
			res_vec_q <= disp.vector;
			res_halt_q <= raised;
			res_stop_q <= stop_n;
		end
	end

	assign result.valid = res_valid_q;
	assign result.divider_value = res_div_q;
	assign result.timer_value = res_tmr_q;
	assign result.pending_flags = res_flags_q;
	assign result.dispatch = res_disp_q;
	assign result.vector_address = res_vec_q;
	assign result.halt_release = res_halt_q;
	assign result.stop_release = res_stop_q;

endmodule

// ===== design/tic_checker.sv =====
// Port-level checks of the timer and interrupt controller, bound to the top level.
module tic_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       res_valid,
	input logic                       res_ready,
	input logic [tic_pkg::FLAG_W-1:0] res_flags,
	input logic                       res_dispatch,
	input logic [tic_pkg::VEC_W-1:0]  res_vector
);
	import tic_pkg::*;

	// A beat without a dispatch carries no vector.
	a_no_vector: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_dispatch) |-> (res_vector == '0))
		else $error("vector set without a dispatch");

	// A dispatched vector lies on the 8-byte grid above the base.
	a_vector_grid: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_dispatch) |->
		((res_vector[7:6] == 2'b01) && (res_vector[2:0] == 3'b000)
		&& (res_vector[5:3] < 3'd5)))
		else $error("dispatched vector off the grid");

	// The dispatched source no longer shows as pending.
	a_flag_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_dispatch && (res_vector[5:3] < 3'd5)) |->
		!res_flags[res_vector[5:3]])
		else $error("dispatched source still pending");

	// A stalled result beat stays put.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=>
		(res_valid && $stable(res_flags) && $stable(res_vector) && $stable(res_dispatch)))
		else $error("stalled result changed");

endmodule

bind timer_and_interrupt_controller_top tic_checker u_tic_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.res_valid    (result.valid),
	.res_ready    (result.ready),
	.res_flags    (result.pending_flags),
	.res_dispatch (result.dispatch),
	.res_vector   (result.vector_address)
);
